[src/assert_macros.svh]
// assertion helpers for the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, switched off while reset is high
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// implication checked on every rising edge, switched off while reset is high
`define ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

`endif

[src/nts_pkg.sv]
package nts_pkg;

  // byte codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    MODE_SKIP   = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       has_byte;
    logic       token_end;
    logic       line_end;
  } nts_result_t;

  // all results caused by one input byte
  typedef struct packed {
    logic        two;
    nts_result_t r0;
    nts_result_t r1;
  } nts_entry_t;

  typedef struct packed {
    logic       push;
    nts_entry_t entry;
  } nts_push_t;

  function automatic logic is_separator(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_EQUALS) ||
           (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_COMMA);
  endfunction

  function automatic nts_result_t make_result(input logic [7:0] b, input logic has,
                                              input logic tend, input logic lend);
    nts_result_t r;
    r.token_byte = has ? b : CH_NUL;
    r.has_byte   = has;
    r.token_end  = tend;
    r.line_end   = lend;
    return r;
  endfunction

endpackage

[src/nts_front.sv]
module nts_front
  import nts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       space,
  output logic       in_ready,
  output nts_push_t  push
);

  scan_mode_t mode, mode_next;
  logic       quote_is_single, quote_is_single_next;
  logic       backslash_pending, backslash_pending_next;
  logic       accept;
  logic [7:0] quote_char;
  nts_entry_t entry;
  logic       emit;

  assign in_ready   = space;
  assign accept     = in_valid && space;
  assign quote_char = quote_is_single ? CH_SQUOTE : CH_DQUOTE;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_SKIP;
      quote_is_single   <= 1'b0;
      backslash_pending <= 1'b0;
    end else if (accept) begin
      mode              <= mode_next;
      quote_is_single   <= quote_is_single_next;
      backslash_pending <= backslash_pending_next;
    end
  end

  always_comb begin
    mode_next              = mode;
    quote_is_single_next   = quote_is_single;
    backslash_pending_next = backslash_pending;
    entry                  = '0;
    emit                   = 1'b0;
    case (mode)
      MODE_PLAIN: begin
        emit = 1'b1;
        if (in_byte == CH_NUL) begin
          entry.r0  = make_result(CH_NUL, 1'b0, 1'b1, 1'b1);
          mode_next = MODE_SKIP;
        end else if (is_separator(in_byte)) begin
          entry.r0  = make_result(CH_NUL, 1'b0, 1'b1, 1'b0);
          mode_next = MODE_SKIP;
        end else begin
          entry.r0 = make_result(in_byte, 1'b1, 1'b0, 1'b0);
        end
      end
      MODE_QUOTED: begin
        if (backslash_pending) begin
          emit     = 1'b1;
          entry.r0 = make_result(CH_BSLASH, 1'b1, 1'b0, 1'b0);
          if (in_byte == quote_char) begin
            entry.r0               = make_result(quote_char, 1'b1, 1'b0, 1'b0);
            backslash_pending_next = 1'b0;
          end else if (in_byte == CH_BSLASH) begin
            backslash_pending_next = 1'b1;
          end else if (in_byte == CH_NUL) begin
            entry.two              = 1'b1;
            entry.r1               = make_result(CH_NUL, 1'b0, 1'b1, 1'b1);
            mode_next              = MODE_SKIP;
            quote_is_single_next   = 1'b0;
            backslash_pending_next = 1'b0;
          end else begin
            entry.two              = 1'b1;
            entry.r1               = make_result(in_byte, 1'b1, 1'b0, 1'b0);
            backslash_pending_next = 1'b0;
          end
        end else if (in_byte == quote_char) begin
          emit                 = 1'b1;
          entry.r0             = make_result(CH_NUL, 1'b0, 1'b1, 1'b0);
          mode_next            = MODE_SKIP;
          quote_is_single_next = 1'b0;
        end else if (in_byte == CH_NUL) begin
          emit                 = 1'b1;
          entry.r0             = make_result(CH_NUL, 1'b0, 1'b1, 1'b1);
          mode_next            = MODE_SKIP;
          quote_is_single_next = 1'b0;
        end else if (in_byte == CH_BSLASH) begin
          backslash_pending_next = 1'b1;
        end else begin
          emit     = 1'b1;
          entry.r0 = make_result(in_byte, 1'b1, 1'b0, 1'b0);
        end
      end
      default: begin
        // skipping separators; the spare mode code behaves the same
        if (in_byte == CH_NUL) begin
          emit                   = 1'b1;
          entry.r0               = make_result(CH_NUL, 1'b0, 1'b0, 1'b1);
          mode_next              = MODE_SKIP;
          quote_is_single_next   = 1'b0;
          backslash_pending_next = 1'b0;
        end else if (is_separator(in_byte)) begin
          mode_next = MODE_SKIP;
        end else if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE) begin
          mode_next              = MODE_QUOTED;
          quote_is_single_next   = (in_byte == CH_SQUOTE);
          backslash_pending_next = 1'b0;
        end else begin
          emit      = 1'b1;
          entry.r0  = make_result(in_byte, 1'b1, 1'b0, 1'b0);
          mode_next = MODE_PLAIN;
        end
      end
    endcase
    push.push  = accept && emit;
    push.entry = entry;
  end

endmodule

[src/nts_queue.sv]
module nts_queue
  import nts_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  nts_push_t  push,
  input  logic       pop,
  output logic       space,
  output logic       q_valid,
  output nts_entry_t q_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  nts_entry_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign space   = (count != FULL_CNT);
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];
  assign do_push = push.push && space;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/nts_back.sv]
module nts_back
  import nts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  nts_entry_t  q_data,
  output logic        pop,
  input  logic        out_ready,
  output logic        out_valid,
  output nts_result_t res,
  output logic        last
);

  logic        load;
  logic        pend;
  nts_result_t second;

  assign load = !out_valid || out_ready;
  assign pop  = load && !pend && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (q_valid) begin
        out_valid <= 1'b1;
        pend      <= q_data.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend) begin
        res  <= second;
        last <= 1'b1;
      end else if (q_valid) begin
        res    <= q_data.r0;
        last   <= !q_data.two;
        second <= q_data.r1;
      end
    end
  end

endmodule

[src/netlist_token_splitter_unit.sv]
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_byte
// out     | output    | out_valid/ out_ready | token_byte, has_byte, token_end, line_end, last
//
// one line byte is taken per cycle while in_ready is high; each byte gives
// zero, one or two results; results leave the output register one per cycle
// while out_ready is high, so a byte with two results takes an extra output
// transfer, absorbed by the front/back queue
// reset is synchronous, there is no clearing pass
// in_ready falls only while the queue is full; out_ready low stalls the back only

`include "assert_macros.svh"

module netlist_token_splitter_unit
  import nts_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] token_byte,
  output logic       has_byte,
  output logic       token_end,
  output logic       line_end,
  output logic       last
);

  // front to queue
  nts_push_t   push;
  logic        space;
  // queue to back
  logic        q_valid;
  nts_entry_t  q_data;
  logic        pop;
  // output register contents
  nts_result_t res;

  // front: tracks scan mode and turns each byte into an entry of results
  nts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .space    (space),
    .in_ready (in_ready),
    .push     (push)
  );

  // short queue so that either side can stall without holding the other
  nts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .pop     (pop),
    .space   (space),
    .q_valid (q_valid),
    .q_data  (q_data)
  );

  // back: splits an entry into one transfer per result
  nts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res       (res),
    .last      (last)
  );

  assign token_byte = res.token_byte;
  assign has_byte   = res.has_byte;
  assign token_end  = res.token_end;
  assign line_end   = res.line_end;

  // a line end is always the final result of its byte
  `ASSERT_IMPL(a_line_end_last, clk, rst, out_valid && line_end, last, "line end without last")
  // a token character never closes a token in the same result
  `ASSERT_IMPL(a_byte_not_end, clk, rst, out_valid && has_byte, !token_end && !line_end,
               "token byte carries an end mark")
  // an empty result carries no character bits
  `ASSERT_IMPL(a_empty_zero, clk, rst, out_valid && !has_byte, token_byte == CH_NUL,
               "empty result with nonzero byte")
  // the queue never takes an entry while no slot is free
  `ASSERT_CLK(a_no_overflow, clk, rst, !(push.push && !space), "queue overflow")

endmodule
